// ===== rtl/core/label_bounding_box_accumulator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the label bounding box accumulator
// Concurrent checks clocked on clk, LBBA_ASSERT ones disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDING_BOX_ACCUMULATOR_MACROS_SVH
`define LABEL_BOUNDING_BOX_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH
`define LBBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LBBA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBBA_ASSERT(name, prop, msg)
`define LBBA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/core/lbba_pkg.sv =====
// ----------------------------------------------------------------------------
// lbba_pkg
// Types, codes and sizes shared by the bounding box accumulator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbba_pkg;

  localparam int LABEL_BITS  = 8;
  localparam int LABEL_COUNT = 1 << LABEL_BITS;
  localparam int COORD_BITS  = 12;
  localparam int WIDTH_BITS  = COORD_BITS + 1;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // register select (paddr bit REG_SEL_BIT)
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [LABEL_BITS-1:0] label_t;

  typedef struct packed {
    logic [1:0] kind;
    label_t     label;
  } pix_word_t;

  typedef struct packed {
    label_t label_res;
    logic   present;
    coord_t min_col;
    coord_t min_row;
    coord_t max_col;
    coord_t max_row;
  } res_word_t;

  typedef struct packed {
    coord_t max_row;
    coord_t max_col;
    coord_t min_row;
    coord_t min_col;
  } box_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
  } pos_t;

  typedef struct packed {
    logic clear;
    logic step;
  } pos_ctl_t;

endpackage

// ===== rtl/core/lbba_pos_counter.sv =====
// ----------------------------------------------------------------------------
// lbba_pos_counter
// Raster position counter: column wraps at the image width, row saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "label_bounding_box_accumulator_macros.svh"

module lbba_pos_counter
  import lbba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [WIDTH_BITS-1:0] image_width,
  input  pos_ctl_t              ctl,
  output pos_t                  pos
);

  coord_t                col;
  coord_t                row;
  logic [WIDTH_BITS-1:0] col_inc;
  logic                  wrap;

  assign col_inc = {1'b0, col} + WIDTH_BITS'(1);
  // a zero width wraps every pixel; a width past the range wraps at the top column
  assign wrap    = (col_inc >= image_width) || (col == '1);
  assign pos     = '{col: col, row: row};

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      col <= '0;
      row <= '0;
    end else if (ctl.step) begin
      if (wrap) begin
        col <= '0;
        if (row != '1) begin
          row <= row + coord_t'(1);
        end
      end else begin
        col <= col_inc[COORD_BITS-1:0];
      end
    end
  end

  `LBBA_ASSERT(a_row_monotone, ctl.step && !ctl.clear |=> row >= $past(row), "row went back")
  `LBBA_ASSERT(a_col_step, ctl.step && !ctl.clear |=> (col == $past(col) + coord_t'(1)) || (col == '0), "column skipped")
  `LBBA_ASSERT(a_clear_zero, ctl.clear |=> (col == '0) && (row == '0), "position not cleared")

endmodule

// ===== rtl/core/label_bounding_box_accumulator.sv =====
// ----------------------------------------------------------------------------
// label_bounding_box_accumulator
// Per-label bounding boxes over a raster stream of pixel labels.
// ----------------------------------------------------------------------------
// The block takes one word per cycle: a pixel, a start-of-frame or a query.
// A word is registered on entry, the box store (256 x 48-bit memory) is read
// at that edge and written back at the following edge, with a bypass for the box
// just written, so back-to-back pixels of one label cost nothing. Seen flags
// live in flip-flops, so a start clears all of them together with no sweep.
// A query result passes from the stage-one register into the result register;
// the input stalls only while a query sits behind a stalled result register.
// The user must write image_width (offset 0) only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "label_bounding_box_accumulator_macros.svh"

module label_bounding_box_accumulator
  import lbba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pix_word_t            pix_word,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_word_t            res_word,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [WIDTH_BITS-1:0]  image_width;
  logic                   cfg_wr;

  logic                   accept;
  pos_ctl_t               pos_ctl;
  pos_t                   pos;

  logic                   s1_valid;
  logic [1:0]             s1_kind;
  label_t                 s1_label;
  pos_t                   s1_pos;
  logic                   s1_hold;
  logic                   s1_fire;
  logic                   s1_seen;

  box_t                   box_mem [LABEL_COUNT];
  box_t                   rd_box;
  box_t                   old_box;
  box_t                   new_box;
  logic                   wr_en;

  logic [LABEL_COUNT-1:0] seen;
  logic                   last_valid;
  label_t                 last_label;
  box_t                   last_box;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (cfg_wr && (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH)) begin
      image_width <= pwdata[WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH) begin
      prdata = {{(DATA_BITS-WIDTH_BITS){1'b0}}, image_width};
    end
  end

  // entry
  assign s1_hold   = s1_valid && (s1_kind == KIND_QUERY) && res_valid && res_stall;
  assign pix_stall = s1_hold;
  assign accept    = pix_valid && !pix_stall;
  assign s1_fire   = s1_valid && !s1_hold;

  assign pos_ctl.step  = accept && (pix_word.kind == KIND_PIXEL);
  assign pos_ctl.clear = accept && (pix_word.kind == KIND_START);

  lbba_pos_counter u_pos (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .ctl         (pos_ctl),
    .pos         (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= pix_word.kind;
      s1_label <= pix_word.label;
      s1_pos   <= pos;
    end
  end

  // box store: read at entry, write back from stage one
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_box <= box_mem[pix_word.label];
    end
    if (wr_en) begin
      box_mem[s1_label] <= new_box;
    end
  end

  // the write at the edge of our read is not in rd_box yet
  assign old_box = (last_valid && (last_label == s1_label)) ? last_box : rd_box;
  assign s1_seen = seen[s1_label];

  always_comb begin
    new_box.min_col = s1_pos.col;
    new_box.max_col = s1_pos.col;
    new_box.min_row = s1_pos.row;
    new_box.max_row = s1_pos.row;
    if (s1_seen) begin
      if (old_box.min_col < s1_pos.col) new_box.min_col = old_box.min_col;
      if (old_box.max_col > s1_pos.col) new_box.max_col = old_box.max_col;
      if (old_box.min_row < s1_pos.row) new_box.min_row = old_box.min_row;
      if (old_box.max_row > s1_pos.row) new_box.max_row = old_box.max_row;
    end
  end

  assign wr_en = s1_fire && (s1_kind == KIND_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= '0;
      last_valid <= 1'b0;
    end else if (s1_fire && (s1_kind == KIND_START)) begin
      seen       <= '0;
      last_valid <= 1'b0;
    end else if (wr_en) begin
      seen[s1_label] <= 1'b1;
      last_valid     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_label <= s1_label;
      last_box   <= new_box;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && (s1_kind == KIND_QUERY)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_kind == KIND_QUERY)) begin
      res_word.label_res <= s1_label;
      res_word.present   <= s1_seen;
      res_word.min_col   <= s1_seen ? old_box.min_col : '0;
      res_word.min_row   <= s1_seen ? old_box.min_row : '0;
      res_word.max_col   <= s1_seen ? old_box.max_col : '0;
      res_word.max_row   <= s1_seen ? old_box.max_row : '0;
    end
  end

  `LBBA_ASSERT(a_stall_cause, pix_stall |-> s1_valid && (s1_kind == KIND_QUERY) && res_valid, "stall without a blocked query")
  `LBBA_ASSERT(a_absent_zero, res_valid && !res_word.present |-> (res_word.min_col == '0) && (res_word.max_col == '0) && (res_word.min_row == '0) && (res_word.max_row == '0), "absent label with nonzero box")
  `LBBA_ASSERT(a_box_order, res_valid && res_word.present |-> (res_word.min_col <= res_word.max_col) && (res_word.min_row <= res_word.max_row), "box corners out of order")
  `LBBA_ASSERT(a_start_clears, s1_fire && (s1_kind == KIND_START) |=> (seen == '0) && !last_valid, "start did not clear seen flags")

endmodule

// ===== bench/label_bounding_box_accumulator_test.sv =====
// ----------------------------------------------------------------------------
// label_bounding_box_accumulator_test
// Drives pixel, start, query and unused words into the accumulator under
// random source idling and sink stalls, and predicts each query's box from
// its own copy of the seen flags, boxes, raster position and image width.
// Covers narrow, typical, wide and zero image widths, frame restarts, and
// input stall behind a held result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module label_bounding_box_accumulator_test;
  import lbba_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] IMAGE_WIDTH_ADDR =
    ADDR_BITS'(REG_IMAGE_WIDTH) << REG_SEL_BIT;
  localparam int IDLE_PCT    = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pix_word_t            pix_word = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_word_t            res_word;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // predicted block state
  bit                    seen_q [LABEL_COUNT];
  box_t                  box_q  [LABEL_COUNT];
  coord_t                col_q;
  coord_t                row_q;
  logic [WIDTH_BITS-1:0] width_q;
  res_word_t             pending_boxes [$];

  bit idle_on = 1'b1;
  int hold_asked = 0;
  int hold_taken;
  int hold_left;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int pixel_count = 0;
  int query_count = 0;
  int width_count = 0;

  label_bounding_box_accumulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Update the predicted state for one accepted word; queue the box a query returns.
  function automatic void apply_word(input pix_word_t w);
    int unsigned nxt;
    box_t        b;
    res_word_t   r;
    case (w.kind)
      KIND_START: begin
        foreach (seen_q[i]) begin
          seen_q[i] = 1'b0;
          box_q[i]  = '0;
        end
        col_q = '0;
        row_q = '0;
      end
      KIND_PIXEL: begin
        pixel_count++;
        b = box_q[w.label];
        if (!seen_q[w.label]) begin
          seen_q[w.label] = 1'b1;
          b = '{max_row: row_q, max_col: col_q, min_row: row_q, min_col: col_q};
        end else begin
          if (col_q < b.min_col) b.min_col = col_q;
          if (row_q < b.min_row) b.min_row = row_q;
          if (col_q > b.max_col) b.max_col = col_q;
          if (row_q > b.max_row) b.max_row = row_q;
        end
        box_q[w.label] = b;
        nxt = col_q + 1;
        if (nxt >= width_q || col_q == '1) begin
          col_q = '0;
          if (row_q != '1) row_q++;
        end else begin
          col_q = nxt[COORD_BITS-1:0];
        end
      end
      KIND_QUERY: begin
        query_count++;
        b = seen_q[w.label] ? box_q[w.label] : '0;
        r.label_res = w.label;
        r.present   = seen_q[w.label];
        r.min_col   = b.min_col;
        r.min_row   = b.min_row;
        r.max_col   = b.max_col;
        r.max_row   = b.max_row;
        pending_boxes.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] kind, input label_t label);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid      <= 1'b1;
    pix_word.kind  <= kind;
    pix_word.label <= label;
    do @(posedge clk); while (pix_stall !== 1'b0);
    apply_word('{kind: kind, label: label});
  endtask

  // Let every query come back, then let the pipeline empty.
  task automatic drain();
    pix_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Optionally write image_width, then read it back and compare.
  task automatic access_width(input bit do_write, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] readback;
    drain();
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= IMAGE_WIDTH_ADDR;
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      width_q = value[WIDTH_BITS-1:0];
      width_count++;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= IMAGE_WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[WIDTH_BITS-1:0] !== width_q) begin
      $error("image_width: expected %0d, got %0d", width_q, readback[WIDTH_BITS-1:0]);
      mismatch_count++;
    end
  endtask

  // Random words: pixels, with starts, queries and unused words by percentage; labels mostly below span.
  task automatic random_stream(input int n, input int span, input int query_pct,
                               input int start_pct);
    int     r;
    label_t lab;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      lab = ($urandom_range(7) == 0) ? label_t'($urandom_range(255))
                                     : label_t'($urandom_range(span - 1));
      if (r < start_pct) send_word(KIND_START, lab);
      else if (r < start_pct + query_pct) send_word(KIND_QUERY, lab);
      else if (r < start_pct + query_pct + 2) send_word(KIND_UNUSED, lab);
      else send_word(KIND_PIXEL, lab);
    end
  endtask

  task automatic test_directed();
    access_width(1'b0, '0);
    send_word(KIND_QUERY, 8'd0);
    send_word(KIND_QUERY, 8'd255);
    send_word(KIND_PIXEL, 8'd0);
    send_word(KIND_PIXEL, 8'd255);
    send_word(KIND_PIXEL, 8'd0);
    send_word(KIND_PIXEL, 8'd0);
    send_word(KIND_QUERY, 8'd0);
    send_word(KIND_UNUSED, 8'd255);
    send_word(KIND_PIXEL, 8'h55);
    send_word(KIND_PIXEL, 8'hAA);
    send_word(KIND_QUERY, 8'h55);
    send_word(KIND_QUERY, 8'hAA);
    send_word(KIND_QUERY, 8'd255);
    send_word(KIND_START, 8'd0);
    send_word(KIND_QUERY, 8'd0);
    send_word(KIND_PIXEL, 8'hAA);
    send_word(KIND_QUERY, 8'hAA);
    send_word(KIND_QUERY, 8'h55);
  endtask

  // Width 1 puts every pixel on a new row.
  task automatic test_narrow_width();
    access_width(1'b1, 32'd1);
    send_word(KIND_START, 8'd0);
    random_stream(120, 16, 2, 0);
    send_word(KIND_PIXEL, 8'd200);
    send_word(KIND_QUERY, 8'd200);
    for (int i = 0; i < 16; i++) send_word(KIND_QUERY, label_t'(i));
  endtask

  // Widths at and past the column range keep one long row; zero wraps every pixel.
  task automatic test_width_extremes();
    access_width(1'b1, 32'd8191);
    send_word(KIND_START, 8'd0);
    random_stream(100, 16, 2, 0);
    for (int i = 0; i < 16; i++) send_word(KIND_QUERY, label_t'(i));
    access_width(1'b1, 32'd4096);
    random_stream(60, 16, 10, 1);
    access_width(1'b1, 32'd0);
    send_word(KIND_START, 8'd0);
    random_stream(40, 8, 20, 0);
  endtask

  // Hold the result side while queries keep coming, so the input stalls.
  task automatic test_backpressure();
    access_width(1'b1, 32'd5);
    send_word(KIND_START, 8'd0);
    random_stream(30, 8, 0, 0);
    hold_asked++;
    random_stream(40, 8, 80, 0);
  endtask

  task automatic test_random();
    access_width(1'b1, 32'd3);
    random_stream(90, 8, 20, 3);
    access_width(1'b1, 32'd17);
    idle_on = 1'b0;
    random_stream(90, 12, 20, 3);
    idle_on = 1'b1;
    access_width(1'b1, 32'd640);
    random_stream(90, 32, 15, 2);
    access_width(1'b1, 32'($urandom_range(64, 1)));
    random_stream(90, 16, 20, 3);
    access_width(1'b1, 32'($urandom_range(4096, 1)));
    random_stream(90, 256, 20, 3);
  endtask

  initial begin
    seen_q  = '{default: 1'b0};
    box_q   = '{default: '0};
    col_q   = '0;
    row_q   = '0;
    width_q = WIDTH_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_narrow_width();
    test_width_extremes();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d pixels and %0d box queries over %0d width writes,",
             pixel_count, query_count, width_count);
    $display("with narrow, wide and zero widths and a long result-side stall");
    if (mismatch_count == 0) begin
      $display("label_bounding_box_accumulator: match");
    end else begin
      $display("label_bounding_box_accumulator: mismatch");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      hold_taken <= 0;
      hold_left  <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      res_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_result
    res_word_t want;
    if (!rst && res_valid === 1'b1 && !res_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("result for label %0d with no query waiting", res_word.label_res);
        mismatch_count++;
      end else begin
        want = pending_boxes.pop_front();
        if (res_word.label_res !== want.label_res) begin
          $error("label_res: expected %0d, got %0d", want.label_res, res_word.label_res);
          mismatch_count++;
        end
        if (res_word.present !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, res_word.present);
          mismatch_count++;
        end
        if (res_word.min_col !== want.min_col) begin
          $error("min_col: expected %0d, got %0d", want.min_col, res_word.min_col);
          mismatch_count++;
        end
        if (res_word.min_row !== want.min_row) begin
          $error("min_row: expected %0d, got %0d", want.min_row, res_word.min_row);
          mismatch_count++;
        end
        if (res_word.max_col !== want.max_col) begin
          $error("max_col: expected %0d, got %0d", want.max_col, res_word.max_col);
          mismatch_count++;
        end
        if (res_word.max_row !== want.max_row) begin
          $error("max_row: expected %0d, got %0d", want.max_row, res_word.max_row);
          mismatch_count++;
        end
      end
    end
  end

  // end the run if no word moves on any port for too long
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("label_bounding_box_accumulator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
